FILE: rtl/core/consecutive_row_jaccard_mean_defines.svh
// assertion macros shared by the jaccard mean block
`ifndef CONSECUTIVE_ROW_JACCARD_MEAN_DEFINES_SVH
`define CONSECUTIVE_ROW_JACCARD_MEAN_DEFINES_SVH
`ifndef SYNTH
`define CRJM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crjm assertion failed");
`define CRJM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crjm assertion failed");
`else
`define CRJM_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define CRJM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/crjm_pkg.sv
// types, constants and helper functions of the jaccard mean block
package crjm_pkg;

   localparam int NUM_COLUMNS_DEF   = 4096;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int COL_W     = 12;
   localparam int CNT_W     = 13;
   localparam int TAG_W     = 32;
   localparam int SUM_W     = 48;
   localparam int DSR_W     = 32;
   localparam int SIM_W     = 17;
   localparam int DIV_CNT_W = $clog2(SUM_W);

   localparam logic [1:0] OP_INDEX   = 2'd0;
   localparam logic [1:0] OP_ROW_END = 2'd1;
   localparam logic [1:0] OP_FINISH  = 2'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef struct packed {
      logic [1:0]       operation;
      logic [COL_W-1:0] column_index;
   } req_type;

   typedef struct packed {
      logic             result_kind;
      logic [SIM_W-1:0] similarity;
      logic [31:0]      pairs_seen;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_START,
      ST_DIVIDE,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic lookup;
      logic row_advance;
      logic div_start_pair;
      logic div_start_mean;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       have_prev;
      logic       pair_zero;
      logic       clear_last;
      logic       div_done;
      logic       rsp_busy;
   } status_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + CNT_W'(1);
   endfunction

   function automatic logic [SIM_W-1:0] clip_sim(input logic [SUM_W-1:0] v);
      return (|v[SUM_W-1:SIM_W]) ? '1 : v[SIM_W-1:0];
   endfunction

endpackage

FILE: rtl/core/crjm_divider.sv
// restoring divider, one quotient bit per cycle
module crjm_divider
   import crjm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DSR_W-1:0]     rem_ff, rem_in;
   logic [SUM_W-1:0]     quot_ff, quot_in;
   logic [DSR_W-1:0]     dsr_ff, dsr_in;
   logic [DSR_W:0]       trial;
   logic [DSR_W:0]       diff;
   logic                 ge;

   assign trial = {rem_ff, quot_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign ge    = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quot_in = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
         quot_in = {quot_ff[SUM_W-2:0], ge};
         if (cnt_ff == DIV_CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      dsr_ff  <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

FILE: rtl/core/crjm_datapath.sv
// tag store, row counters, running sum and result register
`include "consecutive_row_jaccard_mean_defines.svh"
module crjm_datapath
   import crjm_pkg::*;
#(
   parameter int NUM_COLUMNS   = NUM_COLUMNS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output rsp_type    rsp_data
);

   localparam int AddrW = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
   localparam int ExtW  = (AddrW > COL_W) ? AddrW : COL_W;

   logic [TAG_W:0]     tag_mem [NUM_COLUMNS];
   logic [TAG_W:0]     rd_data_ff;
   logic [AddrW-1:0]   clr_addr_ff, clr_addr_in;
   req_type            item_ff;

   logic [TAG_W-1:0]   row_ff, row_in;
   logic               have_prev_ff, have_prev_in;
   logic [CNT_W-1:0]   prev_size_ff, prev_size_in;
   logic [CNT_W-1:0]   cur_size_ff, cur_size_in;
   logic [CNT_W-1:0]   shared_ff, shared_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [31:0]        pairs_ff, pairs_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [ExtW-1:0]    req_col_ext, item_col_ext;
   logic [AddrW-1:0]   req_addr, item_addr;
   logic               in_range, tag_valid, is_dup, is_shared, tag_write;
   logic [TAG_W-1:0]   tag_val;
   logic [CNT_W:0]     uni;
   logic               uni_zero;
   logic [SUM_W-1:0]   sim_full;
   logic [SUM_W:0]     sum_wide;
   logic [31:0]        pairs_next;
   logic               row_done, is_finish;
   logic               div_start, div_busy, div_done;
   logic [SUM_W-1:0]   div_dividend, quotient;
   logic [DSR_W-1:0]   div_divisor;

   assign req_col_ext  = ExtW'(req_data.column_index);
   assign item_col_ext = ExtW'(item_ff.column_index);
   assign req_addr     = req_col_ext[AddrW-1:0];
   assign item_addr    = item_col_ext[AddrW-1:0];

   // tag lookup for an index transaction
   assign in_range  = 32'(item_ff.column_index) < 32'(NUM_COLUMNS);
   assign tag_valid = rd_data_ff[TAG_W];
   assign tag_val   = rd_data_ff[TAG_W-1:0];
   assign is_dup    = tag_valid && (tag_val == row_ff);
   assign is_shared = tag_valid && have_prev_ff && (tag_val == row_ff - TAG_W'(1));
   assign tag_write = cmd.lookup && in_range && !is_dup;

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         tag_mem[clr_addr_ff] <= '0;
      end else if (tag_write) begin
         tag_mem[item_addr] <= {1'b1, row_ff};
      end
      if (cmd.capture) begin
         rd_data_ff <= tag_mem[req_addr];
      end
   end

   // pair similarity and mean share one divider
   assign uni      = {1'b0, prev_size_ff} + {1'b0, cur_size_ff} - {1'b0, shared_ff};
   assign uni_zero = (uni == '0);
   assign div_start    = cmd.div_start_pair || cmd.div_start_mean;
   assign div_dividend = cmd.div_start_mean ? sum_ff : (SUM_W'(shared_ff) << FRACTION_BITS);
   assign div_divisor  = cmd.div_start_mean ? pairs_ff : DSR_W'(uni);

   crjm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   assign sim_full   = uni_zero ? (SUM_W'(1) << FRACTION_BITS) : quotient;
   assign sum_wide   = {1'b0, sum_ff} + {1'b0, sim_full};
   assign pairs_next = (pairs_ff == '1) ? pairs_ff : pairs_ff + 32'd1;
   assign is_finish  = (item_ff.operation == OP_FINISH);
   assign row_done   = cmd.load_rsp && (item_ff.operation == OP_ROW_END);

   always_comb begin
      clr_addr_in  = cmd.clear_step ? clr_addr_ff + AddrW'(1) : clr_addr_ff;
      row_in       = row_ff;
      have_prev_in = have_prev_ff;
      prev_size_in = prev_size_ff;
      cur_size_in  = cur_size_ff;
      shared_in    = shared_ff;
      sum_in       = sum_ff;
      pairs_in     = pairs_ff;
      if (tag_write) begin
         cur_size_in = sat_inc(cur_size_ff);
         if (is_shared) begin
            shared_in = sat_inc(shared_ff);
         end
      end
      if (row_done) begin
         sum_in   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
         pairs_in = pairs_next;
      end
      if (cmd.row_advance || row_done) begin
         prev_size_in = cur_size_ff;
         cur_size_in  = '0;
         shared_in    = '0;
         row_in       = row_ff + TAG_W'(1);
         have_prev_in = 1'b1;
      end
   end

   always_comb begin
      rsp_data_in.result_kind = is_finish;
      if (is_finish) begin
         rsp_data_in.similarity = (pairs_ff == '0) ? '0 : clip_sim(quotient);
         rsp_data_in.pairs_seen = pairs_ff;
      end else begin
         rsp_data_in.similarity = clip_sim(sim_full);
         rsp_data_in.pairs_seen = pairs_next;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         row_ff       <= '0;
         have_prev_ff <= 1'b0;
         prev_size_ff <= '0;
         cur_size_ff  <= '0;
         shared_ff    <= '0;
         sum_ff       <= '0;
         pairs_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         row_ff       <= row_in;
         have_prev_ff <= have_prev_in;
         prev_size_ff <= prev_size_in;
         cur_size_ff  <= cur_size_in;
         shared_ff    <= shared_in;
         sum_ff       <= sum_in;
         pairs_ff     <= pairs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.op         = item_ff.operation;
   assign status.have_prev  = have_prev_ff;
   assign status.pair_zero  = (pairs_ff == '0);
   assign status.clear_last = (clr_addr_ff == AddrW'(NUM_COLUMNS - 1));
   assign status.div_done   = div_done;
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a pending result is never overwritten
   `CRJM_ASSERT_IMPLIES(a_no_rsp_overwrite, clock, reset, cmd.load_rsp,
      !(rsp_valid_ff && !rsp_ready))
   // shared indices are always a subset of the current row
   `CRJM_ASSERT_IMPLIES(a_shared_in_row, clock, reset, 1'b1, shared_ff <= cur_size_ff)
   // the divider is only started when free
   `CRJM_ASSERT_IMPLIES(a_div_free, clock, reset, div_start, !div_busy)
   // a finished division leaves the divider idle
   `CRJM_ASSERT_NEXT(a_done_not_busy, clock, reset, div_done, !div_busy)

endmodule

FILE: rtl/core/crjm_ctrl.sv
// sequencing state machine of the jaccard mean block
module crjm_ctrl
   import crjm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_op,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_op == OP_INDEX) ? ST_LOOKUP : ST_START;
            end
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
         end
         ST_START: begin
            priority if (status.op == OP_ROW_END) begin
               state_in = status.have_prev ? ST_DIVIDE : ST_IDLE;
            end else if (status.op == OP_FINISH) begin
               state_in = status.pair_zero ? ST_RESULT : ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready          = (state_ff == ST_IDLE);
      cmd.capture        = (state_ff == ST_IDLE) && req_valid;
      cmd.clear_step     = (state_ff == ST_CLEAR);
      cmd.lookup         = (state_ff == ST_LOOKUP);
      cmd.row_advance    = (state_ff == ST_START) && (status.op == OP_ROW_END)
                           && !status.have_prev;
      cmd.div_start_pair = (state_ff == ST_START) && (status.op == OP_ROW_END)
                           && status.have_prev;
      cmd.div_start_mean = (state_ff == ST_START) && (status.op == OP_FINISH)
                           && !status.pair_zero;
      cmd.load_rsp       = (state_ff == ST_RESULT) && !status.rsp_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/consecutive_row_jaccard_mean.sv
// Consecutive-row Jaccard similarity mean, top level.
// The req_ channel takes one transaction per sparse-matrix entry: operation
// index carries a column index of the current row, row end closes the row,
// finish asks for the mean over all row pairs so far. The rsp_ channel gives
// at most one transaction per request: the pair similarity at each row end
// after the first, and the mean at each finish (0 when no pair was seen).
// Both channels use valid/ready; rsp_data sits in an output register.
// An index transaction reads the tag store, then writes the row tag back
// for a new in-range column. A first row end starts the next row and an
// unused code is dropped, neither with a result; a finish with no pair
// loads a zero result without the divider. A later row end or a finish with
// pairs runs the 48-step shared divider before its result is loaded.
// After reset the tag store is cleared one entry per cycle, with req_ready
// low; all counters and the running sum start at zero.
// When the receiver stalls, the result waits in the output register; index
// transactions are still taken, and the next result waits in the controller
// until the register is free.
module consecutive_row_jaccard_mean
   import crjm_pkg::*;
#(
   parameter int NUM_COLUMNS   = NUM_COLUMNS_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   crjm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   crjm_datapath #(
      .NUM_COLUMNS   (NUM_COLUMNS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
